>>> src/crsf_rc_frame_receiver_top_assert.svh
// Assertion macros shared by the checker of the channel frame receiver.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef CRSF_RC_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CRSF_RC_FRAME_RECEIVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crsf checker: property violated");

// The consequent must hold in the cycle after the antecedent.
`define CRSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crsf checker: property violated");

`endif

>>> src/crsf_pkg.sv
package crsf_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int NUM_CHANNELS_DEF    = 16;

    // Field widths fixed by the interface.
    localparam int RAW_W   = 11;
    localparam int PULSE_W = 12;
    localparam int CHAN_W  = 4;
    localparam int COEF_W  = 16;

    // Configuration register indexes and reset values.
    localparam int         CFG_INDEX_W        = 2;
    localparam logic [1:0] REG_FRAME_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_OWN_ADDRESS    = 2'd1;
    localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd1100;
    localparam logic [7:0]  OWN_ADDRESS_RST   = 8'd200;

    // Frame layout.
    localparam logic [7:0] RC_TYPE      = 8'h16;
    localparam int         HEADER_GUESS = 5;
    localparam int         PAYLOAD_AT   = 3;
    localparam int         LEN_MIN      = 2;
    localparam int         CHAN_BITS    = 11;

    // CRC-8 DVB-S2.
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Pulse scaling: floor(raw * 40945 / 65536) + 881.
    localparam logic [COEF_W-1:0]  PULSE_COEF   = 16'd40945;
    localparam logic [PULSE_W-1:0] PULSE_OFFSET = 12'd881;

    // Request to the bit-serial CRC unit.
    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } crc_cmd_t;

    // Status of the bit-serial CRC unit.
    typedef struct packed {
        logic busy;
    } crc_status_t;

endpackage

>>> src/crsf_ram.sv
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/crsf_crc.sv
module crsf_crc (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crsf_pkg::crc_cmd_t     cmd,
    output crsf_pkg::crc_status_t  status,
    output logic [7:0]             crc
);

    logic [7:0] crc_reg,  crc_next;
    logic [2:0] step_reg, step_next;
    logic       busy_reg, busy_next;

    // One polynomial step per cycle, eight steps per byte.
    always_comb
    begin
        crc_next  = crc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (cmd.start)
        begin
            crc_next  = (cmd.clear ? 8'd0 : crc_reg) ^ cmd.data;
            step_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (crc_reg[7])
            begin
                crc_next = {crc_reg[6:0], 1'b0} ^ crsf_pkg::CRC_POLY;
            end
            else
            begin
                crc_next = {crc_reg[6:0], 1'b0};
            end
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= 8'd0;
            step_reg <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign status.busy = busy_reg;
    assign crc         = crc_reg;

endmodule

>>> src/crsf_scale.sv
module crsf_scale (
    input  logic                         clk,
    input  logic                         load,
    input  logic [crsf_pkg::RAW_W-1:0]   raw,
    output logic [crsf_pkg::PULSE_W-1:0] pulse
);

    localparam int PROD_W = crsf_pkg::RAW_W + crsf_pkg::COEF_W;

    logic [PROD_W-1:0] prod_reg;

    // The product is registered; the offset add follows in the next cycle.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(raw) * PROD_W'(crsf_pkg::PULSE_COEF);
        end
    end

    assign pulse = crsf_pkg::PULSE_W'(prod_reg[PROD_W-1:crsf_pkg::COEF_W])
                 + crsf_pkg::PULSE_OFFSET;

endmodule

>>> src/crsf_rc_frame_receiver_top.sv
// Receiver for RC-channel frames of the serial radio link protocol. Each request on the rx
// channel is one received byte with its microsecond arrival time; frames are laid out as
// address, length, type, payload and CRC, and a byte that comes more than frame_timeout_us
// after the frame start restarts framing. A length byte below 2 or above MAX_FRAME_BYTES-2
// aborts the frame. A frame whose CRC-8 (polynomial 0xD5, over type and payload) matches,
// whose type is RC channels and whose address equals own_address produces NUM_CHANNELS
// requests on the ch channel, one per channel, with the 11-bit raw value and the pulse width
// floor(raw*40945/65536)+881. Address, length and CRC bytes do not start a CRC pass; a byte
// covered by the CRC holds rx_stall high while the bit-serial CRC unit runs one polynomial
// step per cycle over it. After a good frame the block handles each channel in one or two
// fetches from the single frame-store read port (a FETCH and a LOAD state each), one multiply
// (MUL) and one output load (PUT), which ch_stall can hold; no byte is taken during that time.
// The frame store needs no clearing pass after reset. Configuration writes are always ready and
// must be made only while the block is idle.
module crsf_rc_frame_receiver_top #(
    parameter int MAX_FRAME_BYTES = crsf_pkg::MAX_FRAME_BYTES_DEF,
    parameter int NUM_CHANNELS    = crsf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Byte input channel.
    input  logic                             rx_valid,
    output logic                             rx_stall,
    input  logic [7:0]                       rx_byte,
    input  logic [31:0]                      time_us,
    // Channel result channel.
    output logic                             ch_valid,
    input  logic                             ch_stall,
    output logic [crsf_pkg::CHAN_W-1:0]      channel_index,
    output logic [crsf_pkg::RAW_W-1:0]       raw_value,
    output logic [crsf_pkg::PULSE_W-1:0]     pulse_us,
    output logic                             last_channel,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);

    localparam int ADDR_W  = $clog2(MAX_FRAME_BYTES);
    localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int ACC_W   = crsf_pkg::CHAN_BITS + 7;
    localparam int CNT_W   = $clog2(ACC_W + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CRC   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [2:0]        state_reg,   state_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [31:0]       start_reg,   start_next;
    logic [POS_W-1:0]  len_reg,     len_next;
    logic [7:0]        addr_reg,    addr_next;
    logic [7:0]        type_reg,    type_next;
    logic [ADDR_W-1:0] rd_ptr_reg,  rd_ptr_next;
    logic [ACC_W-1:0]  acc_reg,     acc_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [crsf_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic [15:0]       timeout_reg;
    logic [7:0]        own_addr_reg;
    logic              ch_valid_reg, ch_valid_next;

    logic [crsf_pkg::CHAN_W-1:0]  out_index_reg;
    logic [crsf_pkg::RAW_W-1:0]   out_raw_reg;
    logic [crsf_pkg::PULSE_W-1:0] out_pulse_reg;
    logic                         out_last_reg;

    logic                  rx_accept;
    logic [31:0]           elapsed;
    logic                  restart;
    logic [POS_W-1:0]      pos_eff;
    logic [POS_W-1:0]      pos_inc;
    logic [POS_W-1:0]      full;
    logic                  len_bad;
    logic                  frame_good;
    logic                  chan_last;
    logic [CNT_W-1:0]      cnt_loaded;
    logic                  out_load;

    logic                  ram_we;
    logic                  ram_re;
    logic [7:0]            ram_rdata;

    crsf_pkg::crc_cmd_t    crc_cmd;
    crsf_pkg::crc_status_t crc_status;
    logic [7:0]            crc_value;

    logic                         scale_load;
    logic [crsf_pkg::PULSE_W-1:0] scale_pulse;

    // Byte requests are taken only while the sequencer is idle.
    assign rx_stall  = (state_reg != S_IDLE);
    assign rx_accept = rx_valid && !rx_stall;
    assign cfg_ready = 1'b1;

    // The elapsed time is read as a signed value, so a timestamp that runs backwards never
    // restarts framing.
    assign elapsed = time_us - start_reg;
    assign restart = !elapsed[31] && (elapsed > {16'd0, timeout_reg});
    assign pos_eff = restart ? '0 : pos_reg;
    assign pos_inc = pos_eff + POS_W'(1);

    // Up to and including the type byte the frame is taken to be five bytes long.
    assign full = (pos_eff < POS_W'(crsf_pkg::PAYLOAD_AT))
                ? POS_W'(crsf_pkg::HEADER_GUESS)
                : len_reg + POS_W'(2);

    assign len_bad = (rx_byte < 8'(crsf_pkg::LEN_MIN))
                  || ({1'b0, rx_byte} > 9'(MAX_FRAME_BYTES - 2));

    // Checked when the CRC byte arrives; crc_value then covers type and payload.
    assign frame_good = (crc_value == rx_byte) && (type_reg == crsf_pkg::RC_TYPE)
                     && (addr_reg == own_addr_reg);

    assign chan_last  = (chan_reg == crsf_pkg::CHAN_W'(NUM_CHANNELS - 1));
    assign cnt_loaded = cnt_reg + CNT_W'(8);

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        addr_next     = addr_reg;
        type_next     = type_reg;
        rd_ptr_next   = rd_ptr_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        chan_next     = chan_reg;
        crc_cmd       = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        scale_load    = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (rx_accept)
                begin
                    pos_next = pos_eff;
                    if (pos_eff == '0)
                    begin
                        start_next = time_us;
                    end
                    if (pos_eff < full)
                    begin
                        ram_we = 1'b1;
                        if (pos_eff == POS_W'(0))
                        begin
                            addr_next = rx_byte;
                            pos_next  = pos_inc;
                        end
                        else if (pos_eff == POS_W'(1))
                        begin
                            if (len_bad)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                len_next = POS_W'(rx_byte);
                                pos_next = pos_inc;
                            end
                        end
                        else if (pos_inc == full)
                        begin
                            // CRC byte: the frame is complete.
                            pos_next = '0;
                            if (frame_good)
                            begin
                                state_next  = S_FETCH;
                                rd_ptr_next = ADDR_W'(crsf_pkg::PAYLOAD_AT);
                                acc_next    = '0;
                                cnt_next    = '0;
                                chan_next   = '0;
                            end
                        end
                        else
                        begin
                            // Type or payload byte: fold it into the running CRC.
                            if (pos_eff == POS_W'(2))
                            begin
                                type_next = rx_byte;
                            end
                            crc_cmd.start = 1'b1;
                            crc_cmd.clear = (pos_eff == POS_W'(2));
                            crc_cmd.data  = rx_byte;
                            pos_next      = pos_inc;
                            state_next    = S_CRC;
                        end
                    end
                end
            end

            S_CRC:
            begin
                if (!crc_status.busy)
                begin
                    state_next = S_IDLE;
                end
            end

            S_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                // Append the next payload byte above the bits still held.
                acc_next    = acc_reg | (ACC_W'(ram_rdata) << cnt_reg);
                cnt_next    = cnt_loaded;
                rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                if (cnt_loaded >= CNT_W'(crsf_pkg::CHAN_BITS))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end

            S_MUL:
            begin
                scale_load = 1'b1;
                state_next = S_PUT;
            end

            S_PUT:
            begin
                if (!ch_valid_reg || !ch_stall)
                begin
                    out_load  = 1'b1;
                    acc_next  = acc_reg >> crsf_pkg::CHAN_BITS;
                    cnt_next  = cnt_reg - CNT_W'(crsf_pkg::CHAN_BITS);
                    chan_next = chan_reg + crsf_pkg::CHAN_W'(1);
                    if (chan_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register lets the sequencer go on while the consumer stalls; PUT waits only while it is full.
    always_comb
    begin
        ch_valid_next = ch_valid_reg;
        if (out_load)
        begin
            ch_valid_next = 1'b1;
        end
        else if (ch_valid_reg && !ch_stall)
        begin
            ch_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            start_reg    <= '0;
            ch_valid_reg <= 1'b0;
            timeout_reg  <= crsf_pkg::FRAME_TIMEOUT_RST;
            own_addr_reg <= crsf_pkg::OWN_ADDRESS_RST;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            ch_valid_reg <= ch_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    crsf_pkg::REG_FRAME_TIMEOUT: timeout_reg  <= cfg_data;
                    crsf_pkg::REG_OWN_ADDRESS:   own_addr_reg <= cfg_data[7:0];
                    default:                     ;
                endcase
            end
        end
    end

    // Frame header copies, unpacking state and output payload carry no reset.
    always_ff @(posedge clk)
    begin
        len_next_apply: begin
            len_reg    <= len_next;
            addr_reg   <= addr_next;
            type_reg   <= type_next;
            rd_ptr_reg <= rd_ptr_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            chan_reg   <= chan_next;
        end
        if (out_load)
        begin
            out_index_reg <= chan_reg;
            out_raw_reg   <= acc_reg[crsf_pkg::RAW_W-1:0];
            out_pulse_reg <= scale_pulse;
            out_last_reg  <= chan_last;
        end
    end

    assign ch_valid      = ch_valid_reg;
    assign channel_index = out_index_reg;
    assign raw_value     = out_raw_reg;
    assign pulse_us      = out_pulse_reg;
    assign last_channel  = out_last_reg;

    crsf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_eff[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    crsf_crc u_crc (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (crc_cmd),
        .status (crc_status),
        .crc    (crc_value)
    );

    crsf_scale u_scale (
        .clk   (clk),
        .load  (scale_load),
        .raw   (acc_reg[crsf_pkg::RAW_W-1:0]),
        .pulse (scale_pulse)
    );

endmodule

>>> src/crsf_checker.sv
`include "crsf_rc_frame_receiver_top_assert.svh"

module crsf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             rx_valid,
    input logic                             rx_stall,
    input logic [7:0]                       rx_byte,
    input logic [31:0]                      time_us,
    input logic                             ch_valid,
    input logic                             ch_stall,
    input logic [crsf_pkg::CHAN_W-1:0]      channel_index,
    input logic [crsf_pkg::RAW_W-1:0]       raw_value,
    input logic [crsf_pkg::PULSE_W-1:0]     pulse_us,
    input logic                             last_channel
);

    // A stalled channel request keeps its payload.
    `CRSF_ASSERT_NEXT(a_ch_hold, ch_valid && ch_stall, ch_valid && $stable(channel_index) && $stable(raw_value) && $stable(pulse_us) && $stable(last_channel))

    // While a channel other than the last of a frame is on the output, no new byte is taken.
    `CRSF_ASSERT_NOW(a_busy_mid_frame, ch_valid && !last_channel, rx_stall)

    // A byte taken now cannot produce a channel request in the next cycle.
    `CRSF_ASSERT_NEXT(a_no_instant_result, rx_valid && !rx_stall, !$rose(ch_valid))

    // A stalled byte request keeps its payload.
    `CRSF_ASSERT_NEXT(a_rx_hold, rx_valid && rx_stall, rx_valid && $stable(rx_byte) && $stable(time_us))

endmodule

bind crsf_rc_frame_receiver_top crsf_checker u_crsf_checker (.*);
